// ----- src/adt_pkg.sv -----
// alarm debounce table: shared types, codes and constants
// used by every module of the block; no dependencies
package adt_pkg;

    localparam int NUM_ALARMS_DEF = 32;
    localparam int IDX_W          = 5;
    localparam int RUN_W          = 8;
    localparam int SCAN_W         = 6;
    localparam int CNT_W          = 32;
    localparam int ID_W           = 16;

    localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};
    localparam logic [SCAN_W-1:0] SCAN_MAX = {SCAN_W{1'b1}};

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_RAISE = 2'd1,
        EV_CLEAR = 2'd2
    } t_event;

    // input item
    typedef struct packed {
        t_opcode              opcode;
        logic [IDX_W-1:0]     alarm_index;
        logic                 raw_active;
        logic                 first_of_scan;
        logic [RUN_W-1:0]     occur_threshold;
        logic [RUN_W-1:0]     clear_threshold;
        logic                 no_clear;
        logic [ID_W-1:0]      instance_id;
    } t_in;

    // result item
    typedef struct packed {
        logic [IDX_W-1:0]     report_index;
        t_event               event_res;
        logic [ID_W-1:0]      report_id;
        logic                 qualified_state;
        logic [SCAN_W-1:0]    raised_in_scan;
        logic [SCAN_W-1:0]    cleared_in_scan;
        logic [CNT_W-1:0]     ticks_asserted;
        logic [CNT_W-1:0]     ticks_deasserted;
        logic [CNT_W-1:0]     raise_total;
        logic [CNT_W-1:0]     clear_total;
        logic [CNT_W-1:0]     uptime_ticks;
    } t_out;

    // per-alarm debounce state, one word of the state memory
    typedef struct packed {
        logic                 qualified;
        logic [RUN_W-1:0]     raise_run;
        logic [RUN_W-1:0]     clear_run;
        logic [CNT_W-1:0]     asserted_ticks;
        logic [CNT_W-1:0]     deasserted_ticks;
        logic [CNT_W-1:0]     raise_count;
        logic [CNT_W-1:0]     clear_count;
    } t_stat;

    // per-alarm configuration, one word of the entry memory
    typedef struct packed {
        logic [RUN_W-1:0]     occur_threshold;
        logic [RUN_W-1:0]     clear_threshold;
        logic                 no_clear;
        logic [ID_W-1:0]      instance_id;
    } t_entry;

    // outcome of one evaluation, handed to the top level
    typedef struct packed {
        t_event               ev;
        logic                 raised;
        logic                 cleared;
    } t_eval_flags;

    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
        return (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
    endfunction

    function automatic logic [SCAN_W-1:0] scan_inc(input logic [SCAN_W-1:0] v);
        return (v == SCAN_MAX) ? SCAN_MAX : v + SCAN_W'(1);
    endfunction

endpackage

// ----- src/adt_entry_mem.sv -----
// alarm entry memory: thresholds, no-clear flag and instance id per alarm
// synchronous registered read; uses adt_pkg
module adt_entry_mem #(
    parameter int DEPTH = adt_pkg::NUM_ALARMS_DEF,
    parameter int AW    = 5
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  adt_pkg::t_entry    i_wr_data,
    output adt_pkg::t_entry    o_rd_data
);

    adt_pkg::t_entry r_mem [DEPTH];
    adt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/adt_stat_mem.sv -----
// alarm state memory with per-entry valid bits and write-to-read forwarding
// synchronous registered read; uses adt_pkg
module adt_stat_mem #(
    parameter int DEPTH = adt_pkg::NUM_ALARMS_DEF,
    parameter int AW    = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  adt_pkg::t_stat     i_wr_data,
    output adt_pkg::t_stat     o_rd_data
);

    adt_pkg::t_stat   r_mem [DEPTH];
    adt_pkg::t_stat   r_rd_q;
    adt_pkg::t_stat   r_fwd;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_vld;
    logic             r_hit;

    // valid bits: an entry never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q   <= r_mem[i_rd_addr];
            r_rd_vld <= r_valid[i_rd_addr];
            // same entry written in the read cycle: take the new word
            r_hit    <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd    <= i_wr_data;
        end
    end

    always_comb begin
        if (r_hit) begin
            o_rd_data = r_fwd;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_q;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// ----- src/adt_eval.sv -----
// debounce update of one alarm: tick counts, run counters, raise and clear
// pure combinational; uses adt_pkg
module adt_eval (
    input  logic                  i_sample,
    input  logic                  i_raw,
    input  adt_pkg::t_stat        i_stat,
    input  adt_pkg::t_entry       i_entry,
    output adt_pkg::t_stat        o_stat,
    output adt_pkg::t_eval_flags  o_flags
);

    always_comb begin
        o_stat          = i_stat;
        o_flags.ev      = adt_pkg::EV_NONE;
        o_flags.raised  = 1'b0;
        o_flags.cleared = 1'b0;
        if (i_sample) begin
            if (i_raw) begin
                o_stat.asserted_ticks = i_stat.asserted_ticks + adt_pkg::CNT_W'(1);
            end else begin
                o_stat.deasserted_ticks = i_stat.deasserted_ticks + adt_pkg::CNT_W'(1);
            end

            if (i_stat.qualified != i_raw) begin
                if (i_raw) begin
                    o_stat.raise_run = adt_pkg::run_inc(i_stat.raise_run);
                    o_stat.clear_run = '0;
                    if (o_stat.raise_run == i_entry.occur_threshold) begin
                        o_flags.ev         = adt_pkg::EV_RAISE;
                        o_flags.raised     = 1'b1;
                        o_stat.qualified   = 1'b1;
                        o_stat.raise_count = i_stat.raise_count + adt_pkg::CNT_W'(1);
                    end
                end else if (!i_entry.no_clear) begin
                    o_stat.clear_run = adt_pkg::run_inc(i_stat.clear_run);
                    o_stat.raise_run = '0;
                    if (o_stat.clear_run == i_entry.clear_threshold) begin
                        o_flags.ev         = adt_pkg::EV_CLEAR;
                        o_flags.cleared    = 1'b1;
                        o_stat.qualified   = 1'b0;
                        o_stat.clear_count = i_stat.clear_count + adt_pkg::CNT_W'(1);
                    end
                end
            end else if (i_stat.qualified) begin
                o_stat.clear_run = '0;
            end else begin
                o_stat.raise_run = '0;
            end
        end
    end

endmodule

// ----- src/alarm_debounce_table_unit.sv -----
// alarm debounce table, top level: item pipeline, scan counters, result register
// depends on adt_pkg, adt_entry_mem, adt_stat_mem, adt_eval
//
// usage
//   input channel: i_item is a transfer at a rising edge with start high and
//   busy low. a load item writes the alarm's thresholds, no-clear flag and id;
//   a sample item debounces one raw level of that alarm.
//   result channel: every item gives exactly one result on o_result, shown
//   for one cycle with o_done high; the receiver takes it and cannot stall.
// pipeline and throughput
//   accept cycle: both memories are read at alarm_index (entry info is also
//   written here for a load). next cycle: read-modify-write of the state
//   word, result and o_done registered. one item per cycle sustained while
//   busy is low; the state memory's read-to-write-back loop is closed by a
//   forwarding register, so back-to-back items on the same alarm see each
//   other's updates.
// reset
//   synchronous active-low; busy is high during reset. per-alarm state
//   reads as zero via valid bits (no clearing pass), scan counts and uptime
//   go to zero. entry info is undefined until its alarm is loaded.
module alarm_debounce_table_unit #(
    parameter int NUM_ALARMS = adt_pkg::NUM_ALARMS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  adt_pkg::t_in    i_item,
    output logic            o_done,
    output adt_pkg::t_out   o_result
);

    // only entries reachable by a 5-bit index get storage
    localparam int REACH = 2 ** adt_pkg::IDX_W;
    localparam int DEPTH = (NUM_ALARMS < REACH) ? NUM_ALARMS : REACH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        r_busy;
    logic                        accept;
    logic                        in_range;
    logic [AW-1:0]               acc_addr;

    // compute stage registers
    logic                        r_s1_vld;
    adt_pkg::t_in                r_s1_item;
    logic                        r_s1_inrng;
    logic [AW-1:0]               r_s1_addr;

    // scan and uptime registers
    logic [adt_pkg::SCAN_W-1:0]  r_scan_raised, n_scan_raised;
    logic [adt_pkg::SCAN_W-1:0]  r_scan_cleared, n_scan_cleared;
    logic [adt_pkg::CNT_W-1:0]   r_uptime, n_uptime;
    logic [adt_pkg::SCAN_W-1:0]  base_raised, base_cleared;

    // result register
    logic                        r_done;
    adt_pkg::t_out               r_result, n_result;

    adt_pkg::t_entry             entry_wr, entry_rd;
    adt_pkg::t_stat              stat_rd, stat_new;
    adt_pkg::t_eval_flags        flags;
    logic                        stat_we;
    logic                        sample;

    assign busy     = r_busy;
    assign accept   = start && !r_busy;
    assign in_range = 32'(i_item.alarm_index) < DEPTH;
    assign acc_addr = AW'(i_item.alarm_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // load writes entry info at the accept edge; reads need no forwarding
    assign entry_wr.occur_threshold = i_item.occur_threshold;
    assign entry_wr.clear_threshold = i_item.clear_threshold;
    assign entry_wr.no_clear        = i_item.no_clear;
    assign entry_wr.instance_id     = i_item.instance_id;

    adt_entry_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_entry_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (acc_addr),
        .i_wr_en   (accept && in_range && (i_item.opcode == adt_pkg::OP_LOAD)),
        .i_wr_addr (acc_addr),
        .i_wr_data (entry_wr),
        .o_rd_data (entry_rd)
    );

    // state word read at accept, written back in the compute cycle
    adt_stat_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_stat_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (acc_addr),
        .i_wr_en   (stat_we),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (stat_new),
        .o_rd_data (stat_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= i_item;
            r_s1_inrng <= in_range;
            r_s1_addr  <= acc_addr;
        end
    end

    assign sample  = r_s1_item.opcode == adt_pkg::OP_SAMPLE;
    // write back only sample items on a real entry
    assign stat_we = r_s1_vld && r_s1_inrng && sample;

    adt_eval u_eval (
        .i_sample (sample),
        .i_raw    (r_s1_item.raw_active),
        .i_stat   (stat_rd),
        .i_entry  (entry_rd),
        .o_stat   (stat_new),
        .o_flags  (flags)
    );

    // scan start acts before the item's own raise or clear
    always_comb begin
        base_raised    = r_s1_item.first_of_scan ? '0 : r_scan_raised;
        base_cleared   = r_s1_item.first_of_scan ? '0 : r_scan_cleared;
        n_uptime       = r_uptime + adt_pkg::CNT_W'(r_s1_item.first_of_scan);
        n_scan_raised  = base_raised;
        n_scan_cleared = base_cleared;
        if (r_s1_inrng && flags.raised) begin
            n_scan_raised = adt_pkg::scan_inc(base_raised);
        end
        if (r_s1_inrng && flags.cleared) begin
            n_scan_cleared = adt_pkg::scan_inc(base_cleared);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_raised  <= '0;
            r_scan_cleared <= '0;
            r_uptime       <= '0;
        end else if (r_s1_vld) begin
            r_scan_raised  <= n_scan_raised;
            r_scan_cleared <= n_scan_cleared;
            r_uptime       <= n_uptime;
        end
    end

    // result assembly; an index past the table reports zero per-alarm fields
    always_comb begin
        n_result.report_index    = r_s1_item.alarm_index;
        n_result.raised_in_scan  = n_scan_raised;
        n_result.cleared_in_scan = n_scan_cleared;
        n_result.uptime_ticks    = n_uptime;
        if (r_s1_inrng) begin
            n_result.event_res        = flags.ev;
            n_result.report_id        = (flags.ev == adt_pkg::EV_NONE) ?
                                        '0 : entry_rd.instance_id;
            n_result.qualified_state  = stat_new.qualified;
            n_result.ticks_asserted   = stat_new.asserted_ticks;
            n_result.ticks_deasserted = stat_new.deasserted_ticks;
            n_result.raise_total      = stat_new.raise_count;
            n_result.clear_total      = stat_new.clear_count;
        end else begin
            n_result.event_res        = adt_pkg::EV_NONE;
            n_result.report_id        = '0;
            n_result.qualified_state  = 1'b0;
            n_result.ticks_asserted   = '0;
            n_result.ticks_deasserted = '0;
            n_result.raise_total      = '0;
            n_result.clear_total      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
